[sv/request_retry_scheduler_defines.svh]
// ----------------------------------------------------------------------------
// Request retry scheduler: assertion macros
// Concurrent assertion wrappers, clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef REQUEST_RETRY_SCHEDULER_DEFINES_SVH
`define REQUEST_RETRY_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define RRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// expression must never be true out of reset
`define RRS_NEVER(label, expr, msg) \
    `RRS_ASSERT(label, !(expr), msg)
`else
`define RRS_ASSERT(label, prop, msg)
`define RRS_NEVER(label, expr, msg)
`endif

`endif

[sv/rrs_pkg.sv]
// ----------------------------------------------------------------------------
// Request retry scheduler package
// Field widths, command and status codes, and the records shared by the
// slot table, the task queue and the control sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrs_pkg;

    localparam int IDX_W   = 2;
    localparam int BITS_W  = 32;
    localparam int RETRY_W = 8;
    localparam int IVAL_W  = 16;
    localparam int TIME_W  = 32;
    localparam int DEC_W   = 8;

    localparam logic [DEC_W-1:0]   DEC_RESET     = 8'd6;
    localparam logic [RETRY_W-1:0] RETRY_FOREVER = 8'hFF;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_PENDING = 2'd1,
        ST_NOFREE  = 2'd2,
        ST_NONE    = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd                command;
        logic [IDX_W-1:0]    task_index;
        logic [BITS_W-1:0]   task_bits;
        logic [RETRY_W-1:0]  retry_count;
        logic [IVAL_W-1:0]   retry_interval;
        logic [TIME_W-1:0]   now_ticks;
    } t_req;

    typedef struct packed {
        logic                emit_valid;
        logic [IDX_W-1:0]    emit_index;
        logic [BITS_W-1:0]   emit_bits;
        logic [BITS_W-1:0]   waiting_bits;
        t_status             set_status;
        logic                queue_overflow;
    } t_rsp;

    // one booked request
    typedef struct packed {
        logic [IDX_W-1:0]    grp;
        logic [BITS_W-1:0]   task_bits;
        logic [RETRY_W-1:0]  retries;
        logic [TIME_W-1:0]   last_time;
        logic [IVAL_W-1:0]   interval;
    } t_slot;

    // one queued task
    typedef struct packed {
        logic [IDX_W-1:0]    grp;
        logic [BITS_W-1:0]   bits;
    } t_qent;

    // verdict of the slot evaluation unit
    typedef struct packed {
        logic                match;
        logic                overdue;
        logic                keep;
        t_slot               upd;
    } t_eval;

endpackage

[sv/rrs_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rrs_req_if;
    logic          valid;
    logic          ready;
    rrs_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/rrs_rsp_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rrs_rsp_if;
    logic          valid;
    logic          ready;
    rrs_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/rrs_slot_eval.sv]
// ----------------------------------------------------------------------------
// Slot evaluation unit
// Shared compare/subtract unit applied to one slot per cycle: request match,
// overdue test and retry count-down.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrs_slot_eval (
    input  rrs_pkg::t_slot                 i_slot,
    input  logic                           i_valid,
    input  logic [rrs_pkg::IDX_W-1:0]      i_grp,
    input  logic [rrs_pkg::BITS_W-1:0]     i_bits,
    input  logic [rrs_pkg::TIME_W-1:0]     i_now,
    output rrs_pkg::t_eval                 o_res
);
    import rrs_pkg::*;

    logic [TIME_W-1:0]  age;
    logic [RETRY_W-1:0] retries_dec;

    assign age = i_now - i_slot.last_time;

    always_comb begin
        retries_dec = i_slot.retries;
        o_res.keep  = 1'b1;
        // forever never counts down
        if (i_slot.retries != RETRY_FOREVER) begin
            if (i_slot.retries != '0) begin
                retries_dec = i_slot.retries - 1'b1;
            end
            o_res.keep = (retries_dec != '0);
        end
        o_res.match   = i_valid && (i_slot.grp == i_grp) && (i_slot.task_bits == i_bits);
        o_res.overdue = i_valid && (age >= TIME_W'(i_slot.interval));
        o_res.upd     = i_slot;
        o_res.upd.retries   = retries_dec;
        o_res.upd.last_time = i_now;
    end
endmodule

[sv/rrs_slot_table.sv]
// ----------------------------------------------------------------------------
// Slot table
// Request slot memory with one registered read port and one write port;
// booked flags held in flops and cleared by reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrs_slot_table #(
    parameter int  SLOTS = 8,
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [SW-1:0]    i_rd_addr,
    output rrs_pkg::t_slot   o_rd_data,
    input  logic             i_wr_en,
    input  logic [SW-1:0]    i_wr_addr,
    input  rrs_pkg::t_slot   i_wr_data,
    input  logic             i_wr_valid,
    output logic [SLOTS-1:0] o_valid
);
    import rrs_pkg::*;

    t_slot            mem [SLOTS];
    t_slot            r_rd_data;
    logic [SLOTS-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= i_wr_valid;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_valid   = r_valid;
endmodule

[sv/rrs_queue.sv]
// ----------------------------------------------------------------------------
// Task queue
// Circular FIFO of tasks; a push to a full queue is dropped. Pop data is
// registered and holds until the next pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrs_queue #(
    parameter int  DEPTH = 16,
    localparam int QW    = $clog2(DEPTH),
    localparam int FW    = $clog2(DEPTH + 1),
    localparam int SUMW  = QW + 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rrs_pkg::t_qent i_push_data,
    input  logic           i_pop,
    output rrs_pkg::t_qent o_pop_data,
    output logic           o_full,
    output logic           o_empty
);
    import rrs_pkg::*;

    t_qent          mem [DEPTH];
    t_qent          r_pop_data;
    logic [QW-1:0]  r_head;
    logic [FW-1:0]  r_fill;
    logic [SUMW-1:0] sum;
    logic [SUMW-1:0] tail;

    assign o_full  = (r_fill == FW'(DEPTH));
    assign o_empty = (r_fill == '0);

    // head + fill stays below twice the depth: one compare and subtract
    assign sum  = SUMW'(r_head) + SUMW'(r_fill);
    assign tail = (sum >= SUMW'(DEPTH)) ? (sum - SUMW'(DEPTH)) : sum;

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            mem[tail[QW-1:0]] <= i_push_data;
        end
        if (i_pop) begin
            r_pop_data <= mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (i_pop && !o_empty) begin
            r_head <= (r_head == QW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            r_fill <= r_fill - 1'b1;
        end else if (i_push && !o_full) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    assign o_pop_data = r_pop_data;
endmodule

[sv/request_retry_scheduler.sv]
// ----------------------------------------------------------------------------
// Request retry scheduler
// Every command beat gives exactly one result beat. Clear, tick and a set with
// nonzero retry count and task bits walk the request slots through the single
// read port of the slot table, one slot a cycle, then go through a finishing
// state to the output state, which loads the result register. Any other set
// and the no-op go from the accept straight to the output state. The block
// takes a new command only once the previous one has gone to the result
// register, which may still be waiting for the sink.
// There is no clearing pass after reset. The decimation register may be
// written only while no command is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "request_retry_scheduler_defines.svh"

module request_retry_scheduler #(
    parameter int REQUEST_SLOTS = 8,
    parameter int TASK_GROUPS   = 4,
    parameter int QUEUE_DEPTH   = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [rrs_pkg::DEC_W-1:0] i_cfg_wdata,
    rrs_req_if.sink                   i_req,
    rrs_rsp_if.source                 o_rsp
);
    import rrs_pkg::*;

    localparam int SW = (REQUEST_SLOTS > 1) ? $clog2(REQUEST_SLOTS) : 1;
    localparam int CW = $clog2(REQUEST_SLOTS + 1);
    localparam int GW = (TASK_GROUPS > 1) ? $clog2(TASK_GROUPS) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_FIN  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    // group index reduced into range by repeated subtraction
    function automatic logic [IDX_W-1:0] f_grp(input logic [IDX_W-1:0] idx);
        logic [4:0] g;
        g = 5'(idx);
        for (int k = 0; k < 3; k++) begin
            if (g >= 5'(TASK_GROUPS)) begin
                g = g - 5'(TASK_GROUPS);
            end
        end
        return g[IDX_W-1:0];
    endfunction

    // control state
    t_state              r_state, n_state;
    logic [DEC_W-1:0]    r_dec;
    logic [TIME_W-1:0]   r_last_pop, n_last_pop;
    logic [BITS_W-1:0]   r_wait [TASK_GROUPS];
    logic [BITS_W-1:0]   n_wait [TASK_GROUPS];
    logic                r_out_valid, n_out_valid;
    logic                r_rd_v, n_rd_v;

    // per-command working registers
    t_cmd                r_cmd, n_cmd;
    logic [IDX_W-1:0]    r_grp, n_grp;
    logic [BITS_W-1:0]   r_bits, n_bits;
    logic [RETRY_W-1:0]  r_retry, n_retry;
    logic [IVAL_W-1:0]   r_ival, n_ival;
    logic [TIME_W-1:0]   r_now, n_now;
    t_status             r_status, n_status;
    logic                r_ovf, n_ovf;
    logic                r_emit, n_emit;
    logic                r_pending, n_pending;
    logic                r_free_ok, n_free_ok;
    logic [SW-1:0]       r_free, n_free;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [SW-1:0]       r_rd_idx, n_rd_idx;
    t_rsp                r_out, n_out;

    // slot table and queue hookup
    logic                tb_rd_en, tb_wr_en, tb_wr_valid;
    logic [SW-1:0]       tb_rd_addr, tb_wr_addr;
    t_slot               tb_rd_data, tb_wr_data;
    logic [REQUEST_SLOTS-1:0] tb_valid;
    logic                q_push, q_pop, q_full, q_empty;
    t_qent               q_push_data, q_pop_data;
    t_eval               ev;
    t_req                req;
    logic                accept;
    logic [IDX_W-1:0]    in_grp;
    logic                slot_v;
    logic                walk_issue;
    logic [TIME_W-1:0]   pop_age;

    assign req      = i_req.data;
    assign accept   = i_req.valid && i_req.ready;
    assign in_grp   = f_grp(req.task_index);
    assign slot_v   = tb_valid[r_rd_idx];
    assign pop_age  = r_now - r_last_pop;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    rrs_slot_table #(.SLOTS(REQUEST_SLOTS)) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (tb_rd_en),
        .i_rd_addr  (tb_rd_addr),
        .o_rd_data  (tb_rd_data),
        .i_wr_en    (tb_wr_en),
        .i_wr_addr  (tb_wr_addr),
        .i_wr_data  (tb_wr_data),
        .i_wr_valid (tb_wr_valid),
        .o_valid    (tb_valid)
    );

    rrs_slot_eval u_eval (
        .i_slot  (tb_rd_data),
        .i_valid (slot_v),
        .i_grp   (r_grp),
        .i_bits  (r_bits),
        .i_now   (r_now),
        .o_res   (ev)
    );

    rrs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_pop_data  (q_pop_data),
        .o_full      (q_full),
        .o_empty     (q_empty)
    );

    always_comb begin
        n_state     = r_state;
        n_last_pop  = r_last_pop;
        n_wait      = r_wait;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_rd_v      = 1'b0;
        n_cmd       = r_cmd;
        n_grp       = r_grp;
        n_bits      = r_bits;
        n_retry     = r_retry;
        n_ival      = r_ival;
        n_now       = r_now;
        n_status    = r_status;
        n_ovf       = r_ovf;
        n_emit      = r_emit;
        n_pending   = r_pending;
        n_free_ok   = r_free_ok;
        n_free      = r_free;
        n_cnt       = r_cnt;
        n_rd_idx    = r_rd_idx;
        n_out       = r_out;
        tb_rd_en    = 1'b0;
        tb_rd_addr  = r_cnt[SW-1:0];
        tb_wr_en    = 1'b0;
        tb_wr_addr  = r_rd_idx;
        tb_wr_data  = ev.upd;
        tb_wr_valid = 1'b0;
        q_push      = 1'b0;
        q_push_data = '{grp: tb_rd_data.grp, bits: tb_rd_data.task_bits};
        q_pop       = 1'b0;
        walk_issue  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd     = req.command;
                    n_grp     = in_grp;
                    n_bits    = req.task_bits;
                    n_retry   = req.retry_count;
                    n_ival    = req.retry_interval;
                    n_now     = req.now_ticks;
                    n_status  = ST_NONE;
                    n_ovf     = 1'b0;
                    n_emit    = 1'b0;
                    n_pending = 1'b0;
                    n_free_ok = 1'b0;
                    n_cnt     = '0;
                    unique case (req.command)
                        CMD_SET: begin
                            q_push      = 1'b1;
                            q_push_data = '{grp: in_grp, bits: req.task_bits};
                            n_ovf       = q_full;
                            n_wait[GW'(in_grp)] = r_wait[GW'(in_grp)] | req.task_bits;
                            if (req.retry_count != '0 && req.task_bits != '0) begin
                                n_state = S_WALK;
                            end else begin
                                n_state = S_OUT;
                            end
                        end
                        CMD_CLEAR: begin
                            n_state = S_WALK;
                        end
                        CMD_TICK: begin
                            // masks are rebuilt from the booked slots
                            for (int g = 0; g < TASK_GROUPS; g++) begin
                                n_wait[g] = '0;
                            end
                            n_state = S_WALK;
                        end
                        CMD_NOP: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end

            S_WALK: begin
                // read slot r_cnt while slot r_rd_idx is evaluated
                walk_issue = (r_cnt < CW'(REQUEST_SLOTS));
                tb_rd_en   = walk_issue;
                if (walk_issue) begin
                    n_cnt    = r_cnt + 1'b1;
                    n_rd_v   = 1'b1;
                    n_rd_idx = r_cnt[SW-1:0];
                end
                if (r_rd_v) begin
                    unique case (r_cmd)
                        CMD_SET: begin
                            if (ev.match) begin
                                n_pending = 1'b1;
                            end
                            if (!slot_v && !r_free_ok) begin
                                n_free_ok = 1'b1;
                                n_free    = r_rd_idx;
                            end
                        end
                        CMD_CLEAR: begin
                            if (ev.match) begin
                                tb_wr_en    = 1'b1;
                                tb_wr_valid = 1'b0;
                                n_wait[GW'(r_grp)] = r_wait[GW'(r_grp)] & ~r_bits;
                            end
                        end
                        CMD_TICK: begin
                            if (slot_v) begin
                                n_wait[GW'(tb_rd_data.grp)] =
                                    r_wait[GW'(tb_rd_data.grp)] | tb_rd_data.task_bits;
                            end
                            if (ev.overdue) begin
                                q_push      = 1'b1;
                                tb_wr_en    = 1'b1;
                                tb_wr_valid = ev.keep;
                                if (q_full) begin
                                    n_ovf = 1'b1;
                                end
                            end
                        end
                        CMD_NOP: begin
                        end
                    endcase
                    if (r_rd_idx == SW'(REQUEST_SLOTS - 1)) begin
                        n_state = S_FIN;
                    end
                end
            end

            S_FIN: begin
                if (r_cmd == CMD_SET) begin
                    priority if (r_pending) begin
                        n_status = ST_PENDING;
                    end else if (!r_free_ok) begin
                        n_status = ST_NOFREE;
                    end else begin
                        n_status    = ST_ADDED;
                        tb_wr_en    = 1'b1;
                        tb_wr_addr  = r_free;
                        tb_wr_valid = 1'b1;
                        tb_wr_data  = '{grp: r_grp, task_bits: r_bits, retries: r_retry,
                                        last_time: r_now, interval: r_ival};
                    end
                end else if (r_cmd == CMD_TICK) begin
                    if (pop_age > TIME_W'(r_dec)) begin
                        n_last_pop = r_now;
                        if (!q_empty) begin
                            q_pop  = 1'b1;
                            n_emit = 1'b1;
                        end
                    end
                end
                n_state = S_OUT;
            end

            S_OUT: begin
                // hold until the result register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out.emit_valid     = r_emit;
                    n_out.emit_index     = r_emit ? q_pop_data.grp : '0;
                    n_out.emit_bits      = r_emit ? q_pop_data.bits : '0;
                    n_out.waiting_bits   = r_wait[GW'(r_grp)];
                    n_out.set_status     = r_status;
                    n_out.queue_overflow = r_ovf;
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dec       <= DEC_RESET;
            r_last_pop  <= '0;
            r_out_valid <= 1'b0;
            r_rd_v      <= 1'b0;
            for (int g = 0; g < TASK_GROUPS; g++) begin
                r_wait[g] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_last_pop  <= n_last_pop;
            r_out_valid <= n_out_valid;
            r_rd_v      <= n_rd_v;
            r_wait      <= n_wait;
            if (i_cfg_we) begin
                r_dec <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_grp     <= n_grp;
        r_bits    <= n_bits;
        r_retry   <= n_retry;
        r_ival    <= n_ival;
        r_now     <= n_now;
        r_status  <= n_status;
        r_ovf     <= n_ovf;
        r_emit    <= n_emit;
        r_pending <= n_pending;
        r_free_ok <= n_free_ok;
        r_free    <= n_free;
        r_cnt     <= n_cnt;
        r_rd_idx  <= n_rd_idx;
        r_out     <= n_out;
    end

    `RRS_ASSERT(a_accept_busy, (i_req.valid && i_req.ready) |=> !i_req.ready, "accepted a beat while busy")
    `RRS_NEVER(a_push_pop, q_push && q_pop, "queue push and pop in one cycle")
    `RRS_ASSERT(a_walk_bound, (r_state == S_WALK) |-> (r_cnt <= CW'(REQUEST_SLOTS)), "slot walk overran")
    `RRS_ASSERT(a_status_set, (r_state == S_OUT && r_cmd != CMD_SET) |-> (r_status == ST_NONE), "set status on a non-set command")

endmodule

[verif/tb_request_retry_scheduler.sv]
// ----------------------------------------------------------------------------
// Request retry scheduler testbench
// Drives command beats from a backlog queue, predicts every result beat with
// a behavioural copy of the slot table, waiting masks and task FIFO, and
// checks each result beat field by field. Runs a directed opening and then
// random phases under several decimation settings, with random idling on
// both channels, a long result hold-off and drained pauses between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_request_retry_scheduler;
    import rrs_pkg::*;

    localparam int SLOTS  = 8;
    localparam int GROUPS = 4;
    localparam int DEPTH  = 16;
    localparam int HOLD_CYCLES = 300;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [DEC_W-1:0]   i_cfg_wdata = '0;

    rrs_req_if req_if ();
    rrs_rsp_if rsp_if ();

    request_retry_scheduler #(
        .REQUEST_SLOTS (SLOTS),
        .TASK_GROUPS   (GROUPS),
        .QUEUE_DEPTH   (DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // scheduler image
    logic [BITS_W-1:0]  m_task [SLOTS];
    logic [IDX_W-1:0]   m_grp [SLOTS];
    logic [RETRY_W-1:0] m_retry [SLOTS];
    logic [TIME_W-1:0]  m_last [SLOTS];
    logic [IVAL_W-1:0]  m_ival [SLOTS];
    logic [BITS_W-1:0]  m_wait [GROUPS];
    t_qent              m_fifo [DEPTH];
    int                 m_fill;
    int                 m_head;
    logic [TIME_W-1:0]  m_last_pop;
    logic [DEC_W-1:0]   m_decim;

    t_req cmd_backlog[$];
    t_rsp rsp_forecast[$];

    bit   calm = 1'b0;
    int   hold_requests = 0;
    int   hold_served = 0;
    int   hold_left = 0;
    int   mismatches = 0;

    int   n_set = 0, n_clear = 0, n_tick = 0, n_nop = 0;
    int   n_emit = 0, n_overflow = 0;
    int   n_status [4] = '{0, 0, 0, 0};
    string decim_log = "6";

    logic [TIME_W-1:0] now_gen = '0;
    logic [BITS_W-1:0] bit_pool [8];

    function automatic bit fifo_push(logic [IDX_W-1:0] g, logic [BITS_W-1:0] b);
        int pos;
        if (m_fill >= DEPTH) return 1'b0;
        pos = (m_head + m_fill) % DEPTH;
        m_fifo[pos].grp  = g;
        m_fifo[pos].bits = b;
        m_fill++;
        return 1'b1;
    endfunction

    function automatic t_rsp advance_scheduler(t_req rq);
        t_rsp              r;
        int                free_slot;
        bit                already;
        logic [IDX_W-1:0]  g;
        logic [TIME_W-1:0] diff;
        r = '0;
        r.set_status = ST_NONE;
        g = rq.task_index;
        case (rq.command)
            CMD_SET: begin
                if (!fifo_push(g, rq.task_bits)) r.queue_overflow = 1'b1;
                m_wait[g] |= rq.task_bits;
                if (rq.retry_count != 0 && rq.task_bits != 0) begin
                    free_slot = -1;
                    already = 1'b0;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!already) begin
                            if (m_task[i] != 0) begin
                                if (m_grp[i] == g && m_task[i] == rq.task_bits) already = 1'b1;
                            end else if (free_slot < 0) begin
                                free_slot = i;
                            end
                        end
                    end
                    if (already) begin
                        r.set_status = ST_PENDING;
                    end else if (free_slot < 0) begin
                        r.set_status = ST_NOFREE;
                    end else begin
                        m_task[free_slot]  = rq.task_bits;
                        m_grp[free_slot]   = g;
                        m_retry[free_slot] = rq.retry_count;
                        m_last[free_slot]  = rq.now_ticks;
                        m_ival[free_slot]  = rq.retry_interval;
                        r.set_status = ST_ADDED;
                    end
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (m_task[i] != 0 && m_grp[i] == g && m_task[i] == rq.task_bits) begin
                        m_task[i] = '0;
                        m_wait[g] &= ~rq.task_bits;
                    end
                end
            end
            CMD_TICK: begin
                for (int i = 0; i < GROUPS; i++) m_wait[i] = '0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (m_task[i] != 0) begin
                        m_wait[m_grp[i]] |= m_task[i];
                        diff = rq.now_ticks - m_last[i];
                        if (diff >= {16'h0, m_ival[i]}) begin
                            if (!fifo_push(m_grp[i], m_task[i])) r.queue_overflow = 1'b1;
                            m_last[i] = rq.now_ticks;
                            if (m_retry[i] != RETRY_FOREVER) begin
                                if (m_retry[i] != 0) m_retry[i]--;
                                if (m_retry[i] == 0) m_task[i] = '0;
                            end
                        end
                    end
                end
                diff = rq.now_ticks - m_last_pop;
                if (diff > {24'h0, m_decim}) begin
                    m_last_pop = rq.now_ticks;
                    if (m_fill != 0) begin
                        r.emit_valid = 1'b1;
                        r.emit_index = m_fifo[m_head].grp;
                        r.emit_bits  = m_fifo[m_head].bits;
                        m_head = (m_head + 1) % DEPTH;
                        m_fill--;
                    end
                end
            end
            default: ;
        endcase
        r.waiting_bits = m_wait[g];
        return r;
    endfunction

    function automatic t_req make_cmd(t_cmd c, logic [IDX_W-1:0] g, logic [BITS_W-1:0] b,
                                      logic [RETRY_W-1:0] rc, logic [IVAL_W-1:0] iv,
                                      logic [TIME_W-1:0] t);
        t_req rq;
        rq.command        = c;
        rq.task_index     = g;
        rq.task_bits      = b;
        rq.retry_count    = rc;
        rq.retry_interval = iv;
        rq.now_ticks      = t;
        return rq;
    endfunction

    // mostly pooled task bits and slowly advancing time, so that bookings,
    // repeats, clears and retries meet each other
    function automatic t_req random_cmd();
        t_req rq;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 35)      rq.command = CMD_SET;
        else if (pick < 50) rq.command = CMD_CLEAR;
        else if (pick < 95) rq.command = CMD_TICK;
        else                rq.command = CMD_NOP;
        rq.task_index = IDX_W'($urandom_range(GROUPS - 1));
        pick = $urandom_range(99);
        if (pick < 80)      rq.task_bits = bit_pool[$urandom_range(7)];
        else if (pick < 90) rq.task_bits = $urandom;
        else                rq.task_bits = '0;
        pick = $urandom_range(99);
        if (pick < 10)      rq.retry_count = '0;
        else if (pick < 20) rq.retry_count = RETRY_FOREVER;
        else if (pick < 80) rq.retry_count = RETRY_W'($urandom_range(1, 4));
        else                rq.retry_count = RETRY_W'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 85) rq.retry_interval = IVAL_W'($urandom_range(12));
        else           rq.retry_interval = IVAL_W'($urandom_range(65535));
        pick = $urandom_range(99);
        if (pick < 90)      now_gen = now_gen + $urandom_range(3);
        else if (pick < 97) now_gen = now_gen + $urandom_range(40);
        else                now_gen = $urandom;
        rq.now_ticks = now_gen;
        return rq;
    endfunction

    task automatic note_mismatch(string what, logic [BITS_W-1:0] got, logic [BITS_W-1:0] want);
        mismatches++;
        $display("[%0t] mismatch %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // driver: offer backlog beats, predict each accepted one
    always @(posedge i_clk) begin : drive_proc
        bit send;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                rsp_forecast.push_back(advance_scheduler(req_if.data));
                case (req_if.data.command)
                    CMD_SET:   n_set++;
                    CMD_CLEAR: n_clear++;
                    CMD_TICK:  n_tick++;
                    default:   n_nop++;
                endcase
            end
            if (!req_if.valid || req_if.ready) begin
                send = cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= 15);
                if (send) req_if.data <= cmd_backlog.pop_front();
                req_if.valid <= send;
            end
        end
    end

    // long result hold-off, counted on its own
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_requests != hold_served) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
        end
    end

    // monitor: check each accepted result beat against the oldest forecast
    always @(posedge i_clk) begin : watch_proc
        t_rsp got;
        t_rsp want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.data;
                if (got.emit_valid) n_emit++;
                if (got.queue_overflow) n_overflow++;
                n_status[got.set_status]++;
                if (rsp_forecast.size() == 0) begin
                    note_mismatch("unexpected result beat", got.emit_bits, '0);
                end else begin
                    want = rsp_forecast.pop_front();
                    if (got.emit_valid !== want.emit_valid)
                        note_mismatch("emit_valid", got.emit_valid, want.emit_valid);
                    if (got.emit_index !== want.emit_index)
                        note_mismatch("emit_index", got.emit_index, want.emit_index);
                    if (got.emit_bits !== want.emit_bits)
                        note_mismatch("emit_bits", got.emit_bits, want.emit_bits);
                    if (got.waiting_bits !== want.waiting_bits)
                        note_mismatch("waiting_bits", got.waiting_bits, want.waiting_bits);
                    if (got.set_status !== want.set_status)
                        note_mismatch("set_status", got.set_status, want.set_status);
                    if (got.queue_overflow !== want.queue_overflow)
                        note_mismatch("queue_overflow", got.queue_overflow, want.queue_overflow);
                end
            end
            rsp_if.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 15);
        end
    end

    // hold until the backlog is sent and every forecast has been met
    task automatic drain();
        while (cmd_backlog.size() != 0 || req_if.valid || rsp_forecast.size() != 0)
            @(negedge i_clk);
        repeat (14) @(negedge i_clk);
    endtask

    task automatic write_decimation(logic [DEC_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        m_decim = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        decim_log = $sformatf("%s, %0d", decim_log, v);
    endtask

    task automatic random_phase(int count, logic [DEC_W-1:0] v, bit quiet, bit with_hold);
        drain();
        write_decimation(v);
        @(negedge i_clk);
        calm = quiet;
        for (int i = 0; i < count; i++) cmd_backlog.push_back(random_cmd());
        if (with_hold) hold_requests++;
        drain();
        calm = 1'b0;
    endtask

    initial begin
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            m_task[i] = '0;
            m_grp[i] = '0;
            m_retry[i] = '0;
            m_last[i] = '0;
            m_ival[i] = '0;
        end
        for (int i = 0; i < GROUPS; i++) m_wait[i] = '0;
        m_fill = 0;
        m_head = 0;
        m_last_pop = '0;
        m_decim = DEC_RESET;
        bit_pool[0] = 32'hFFFF_FFFF;
        bit_pool[1] = 32'h0000_0001;
        bit_pool[2] = 32'h8000_0000;
        for (int i = 3; i < 8; i++) bit_pool[i] = $urandom;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed opening under the reset decimation
        cmd_backlog.push_back(make_cmd(CMD_TICK, 2'd0, '0, '0, '0, 32'd0));
        // zero task: queued, never booked
        cmd_backlog.push_back(make_cmd(CMD_SET, 2'd0, '0, 8'd3, 16'd5, 32'd1));
        cmd_backlog.push_back(make_cmd(CMD_SET, 2'd1, 32'hFFFF_FFFF, RETRY_FOREVER,
                                       16'hFFFF, 32'd10));
        cmd_backlog.push_back(make_cmd(CMD_SET, 2'd1, 32'hFFFF_FFFF, RETRY_FOREVER,
                                       16'hFFFF, 32'd10));
        cmd_backlog.push_back(make_cmd(CMD_SET, 2'd2, 32'h1, 8'd0, 16'd0, 32'd10));
        cmd_backlog.push_back(make_cmd(CMD_SET, 2'd3, 32'h8000_0000, 8'd1, 16'd0, 32'd10));
        // clear of a request that was never booked
        cmd_backlog.push_back(make_cmd(CMD_CLEAR, 2'd2, 32'h1, '0, '0, 32'd12));
        cmd_backlog.push_back(make_cmd(CMD_TICK, 2'd3, '0, '0, '0, 32'd20));
        cmd_backlog.push_back(make_cmd(CMD_CLEAR, 2'd1, 32'hFFFF_FFFF, '0, '0, 32'd21));
        cmd_backlog.push_back(make_cmd(CMD_NOP, 2'd1, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF,
                                       32'hFFFF_FFFF));
        // nine bookings into eight slots
        for (int i = 0; i < 9; i++)
            cmd_backlog.push_back(make_cmd(CMD_SET, IDX_W'(i % GROUPS), 32'h100 << i, 8'd2,
                                           16'd3, 32'd30));
        // unbooked sets until the FIFO overflows
        for (int i = 0; i < 3; i++)
            cmd_backlog.push_back(make_cmd(CMD_SET, IDX_W'(i), 32'hA5A5_0000 | i, 8'd0, 16'd0,
                                           32'd31));
        // time wraps around zero
        cmd_backlog.push_back(make_cmd(CMD_TICK, 2'd0, '0, '0, '0, 32'hFFFF_FFF0));
        cmd_backlog.push_back(make_cmd(CMD_TICK, 2'd1, '0, '0, '0, 32'd5));
        now_gen = 32'd5;

        random_phase(150, 8'd0, 1'b1, 1'b0);
        random_phase(150, 8'd255, 1'b0, 1'b1);
        random_phase(150, DEC_W'($urandom_range(2, 254)), 1'b0, 1'b0);
        random_phase(150, 8'd1, 1'b0, 1'b0);
        random_phase(100, 8'd3, 1'b0, 1'b1);

        repeat (20) @(posedge i_clk);
        $display("Covered %0d beats: %0d set, %0d clear, %0d tick, %0d no-op; decimation %s",
                 n_set + n_clear + n_tick + n_nop, n_set, n_clear, n_tick, n_nop, decim_log);
        $display("Saw %0d tasks issued, %0d overflow beats, %s %0d/%0d/%0d/%0d",
                 n_emit, n_overflow, "status added/pending/full/none",
                 n_status[0], n_status[1], n_status[2], n_status[3]);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Timeout: %0d results still awaited", rsp_forecast.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
